[rtl/taeu_pkg.sv]
// Shared types, codes and the microcode table of the three-address execute unit.
`default_nettype none

package taeu_pkg;

  localparam int IDX_W       = 10;
  localparam int VAL_W       = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;
  localparam int OP_W        = 3;

  typedef enum logic [2:0] {
    OP_NOOP   = 3'd0,
    OP_INPUT  = 3'd1,
    OP_OUTPUT = 3'd2,
    OP_ASSIGN = 3'd3,
    OP_CJMP   = 3'd4,
    OP_JMP    = 3'd5,
    OP_PARAM  = 3'd6,
    OP_CALL   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ALU_ADD  = 3'd0,
    ALU_SUB  = 3'd1,
    ALU_MUL  = 3'd2,
    ALU_DIV  = 3'd3,
    ALU_MOD  = 3'd4,
    ALU_COPY = 3'd5
  } alu_op_t;

  typedef enum logic [1:0] {
    COND_GT = 2'd0,
    COND_LT = 2'd1,
    COND_NE = 2'd2,
    COND_EQ = 2'd3
  } cond_op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_MOD0 = 2'd2,
    ERR_HALT = 2'd3
  } err_t;

  typedef enum logic [1:0] {RD_NONE, RD_S1, RD_S2, RD_CALLER} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_IN, WR_RES, WR_A} wr_sel_t;
  typedef enum logic [1:0] {BR_NEXT, BR_JUMP, BR_WAIT, BR_NOMD} br_t;

  typedef logic [3:0] uc_addr_t;

  typedef struct packed {
    rd_sel_t  rd;
    logic     lda;
    logic     ldb;
    logic     exec;
    logic     ldmd;
    logic     done;
    wr_sel_t  wr;
    br_t      br;
    uc_addr_t target;
  } ctrl_t;

  // Program entry points.
  localparam uc_addr_t UC_DONE = 4'd0;
  localparam uc_addr_t UC_IN   = 4'd1;
  localparam uc_addr_t UC_OUT  = 4'd2;
  localparam uc_addr_t UC_CJ   = 4'd4;
  localparam uc_addr_t UC_ASG  = 4'd7;
  localparam uc_addr_t UC_RES  = 4'd12;
  localparam uc_addr_t UC_PAR  = 4'd13;

  // Memory reads are registered, so a word is loaded in the step after its read.
  function automatic ctrl_t ucode(input uc_addr_t pc);
    ctrl_t c;
    c = '0;
    case (pc)
      4'd0:  c.done = 1'b1;
      4'd1:  begin c.wr = WR_IN; c.br = BR_JUMP; c.target = UC_DONE; end
      4'd2:  c.rd = RD_S1;
      4'd3:  begin c.lda = 1'b1; c.br = BR_JUMP; c.target = UC_DONE; end
      4'd4:  c.rd = RD_S1;
      4'd5:  begin c.rd = RD_S2; c.lda = 1'b1; end
      4'd6:  begin c.ldb = 1'b1; c.br = BR_JUMP; c.target = UC_DONE; end
      4'd7:  c.rd = RD_S1;
      4'd8:  begin c.rd = RD_S2; c.lda = 1'b1; end
      4'd9:  c.ldb = 1'b1;
      4'd10: begin c.exec = 1'b1; c.br = BR_NOMD; c.target = UC_RES; end
      4'd11: begin c.ldmd = 1'b1; c.br = BR_WAIT; end
      4'd12: begin c.wr = WR_RES; c.br = BR_JUMP; c.target = UC_DONE; end
      4'd13: c.rd = RD_CALLER;
      4'd14: c.lda = 1'b1;
      4'd15: begin c.wr = WR_A; c.br = BR_JUMP; c.target = UC_DONE; end
      default: c.done = 1'b1;
    endcase
    return c;
  endfunction

  function automatic uc_addr_t entry_point(input op_t op);
    uc_addr_t e;
    e = UC_DONE;
    case (op)
      OP_INPUT:  e = UC_IN;
      OP_OUTPUT: e = UC_OUT;
      OP_ASSIGN: e = UC_ASG;
      OP_CJMP:   e = UC_CJ;
      OP_PARAM:  e = UC_PAR;
      default:   e = UC_DONE;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/three_address_execute_unit.sv]
// Top level of the three-address execute unit: sequencer, variable memory and datapath.
`default_nettype none

// Executes one decoded instruction per input word against a memory of MEM_DEPTH
// signed WORD_WIDTH-bit variables and returns exactly one result word per
// instruction. A small microcode table steps a datapath that reads the memory
// through one registered read port, so each operand costs a step. Noop, jump
// and call go straight to their result; multiply, and divide or modulo by a
// nonzero divisor, wait on the bit-serial multiply/divide unit. After reset
// the memory is cleared one entry per cycle, so no word is taken until the
// clearing pass is over. A finished result sits in the output register, so
// the next word can be taken while it waits. Divide or modulo by zero and
// unknown assign operators halt the unit until reset; every later word then
// answers error code 3.
module three_address_execute_unit #(
  parameter int MEM_DEPTH  = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // alu_op[2:0], cond_op[4:3], dest_index[14:5], src1_index[24:15],
  // src2_index[34:25], in_value[66:35], zero fill[71:67]
  input  wire logic [taeu_pkg::IN_TDATA_W-1:0]    s_tdata,
  // operation[2:0]
  input  wire logic [taeu_pkg::OP_W-1:0]          s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // out_valid[0], out_value[32:1], take_target[33], call_start[34],
  // error_code[36:35], zero fill[39:37]
  output logic [taeu_pkg::OUT_TDATA_W-1:0]        m_tdata
);
  import taeu_pkg::*;

  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int IDX_SPAN   = 1 << IDX_W;
  localparam int FOLD_STEPS = $clog2((IDX_SPAN + MEM_DEPTH - 1) / MEM_DEPTH);

  // Index modulo MEM_DEPTH by conditional subtraction of scaled depths.
  function automatic logic [AW-1:0] fold(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] x;
    x = {1'b0, idx};
    for (int k = FOLD_STEPS - 1; k >= 0; k--) begin
      if (x >= (IDX_W + 1)'(MEM_DEPTH << k)) begin
        x = x - (IDX_W + 1)'(MEM_DEPTH << k);
      end
    end
    return AW'(x);
  endfunction

  logic [WORD_WIDTH-1:0] mem [MEM_DEPTH];
  logic [WORD_WIDTH-1:0] rdata;

  logic                  clearing;
  logic [AW-1:0]         clr_addr;
  logic                  running;
  logic                  halted;
  logic                  dead;
  uc_addr_t              pc;

  op_t                   op_q;
  alu_op_t               alu_q;
  cond_op_t              cond_q;
  logic [AW-1:0]         d_addr;
  logic [AW-1:0]         s1_addr;
  logic [AW-1:0]         s2_addr;
  logic [AW-1:0]         caller_addr;
  logic signed [VAL_W-1:0] in_value_q;
  logic [WORD_WIDTH-1:0] a_reg;
  logic [WORD_WIDTH-1:0] b_reg;
  logic [WORD_WIDTH-1:0] res_q;
  err_t                  err_q;

  ctrl_t                 uc;
  logic                  accept;
  logic                  mem_we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic                  uses_md;
  logic                  md_start;
  logic                  md_busy;
  logic [WORD_WIDTH-1:0] md_result;
  logic                  cond_true;
  logic                  out_valid;
  logic [VAL_W-1:0]      out_value;
  logic                  take_target;
  logic                  call_start;
  err_t                  error_code;
  logic                  out_free;

  assign uc       = ucode(pc);
  assign s_tready = !running && !clearing;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign uses_md  = (alu_q == ALU_MUL) ||
                    (((alu_q == ALU_DIV) || (alu_q == ALU_MOD)) && (b_reg != '0));
  assign md_start = running && uc.exec && uses_md;

  always_comb begin
    raddr = s1_addr;
    case (uc.rd)
      RD_S2:     raddr = s2_addr;
      RD_CALLER: raddr = caller_addr;
      default:   raddr = s1_addr;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = d_addr;
    wdata  = a_reg;
    if (clearing) begin
      mem_we = 1'b1;
      waddr  = clr_addr;
      wdata  = '0;
    end else if (running) begin
      case (uc.wr)
        WR_IN: begin
          mem_we = 1'b1;
          wdata  = WORD_WIDTH'(in_value_q);
        end
        WR_RES: begin
          mem_we = (err_q == ERR_NONE);
          wdata  = res_q;
        end
        WR_A: begin
          mem_we = 1'b1;
          wdata  = a_reg;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    case (cond_q)
      COND_GT: cond_true = $signed(a_reg) > $signed(b_reg);
      COND_LT: cond_true = $signed(a_reg) < $signed(b_reg);
      COND_NE: cond_true = a_reg != b_reg;
      default: cond_true = a_reg == b_reg;
    endcase
  end

  always_comb begin
    out_valid   = 1'b0;
    out_value   = '0;
    take_target = 1'b0;
    call_start  = 1'b0;
    error_code  = err_q;
    if (dead) begin
      error_code = ERR_HALT;
    end else begin
      case (op_q)
        OP_OUTPUT: begin
          out_valid = 1'b1;
          out_value = VAL_W'($signed(a_reg));
        end
        OP_CJMP:   take_target = !cond_true;
        OP_JMP:    take_target = 1'b1;
        OP_CALL:   call_start  = 1'b1;
        default:   out_valid   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_addr    <= '0;
      running     <= 1'b0;
      halted      <= 1'b0;
      caller_addr <= '0;
      m_tvalid    <= 1'b0;
      pc          <= UC_DONE;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      // A finishing instruction reloads the output register below instead.
      if (m_tvalid && m_tready && !(running && uc.done)) begin
        m_tvalid <= 1'b0;
      end

      if (accept) begin
        running    <= 1'b1;
        dead       <= halted;
        err_q      <= ERR_NONE;
        op_q       <= op_t'(s_tuser);
        alu_q      <= alu_op_t'(s_tdata[2:0]);
        cond_q     <= cond_op_t'(s_tdata[4:3]);
        d_addr     <= fold(s_tdata[14:5]);
        s1_addr    <= fold(s_tdata[24:15]);
        s2_addr    <= fold(s_tdata[34:25]);
        in_value_q <= s_tdata[66:35];
        pc         <= halted ? UC_DONE : entry_point(op_t'(s_tuser));
      end else if (running) begin
        if (uc.lda) begin
          a_reg <= rdata;
        end
        if (uc.ldb) begin
          b_reg <= rdata;
        end
        if (uc.exec) begin
          case (alu_q)
            ALU_ADD:  res_q <= a_reg + b_reg;
            ALU_SUB:  res_q <= a_reg - b_reg;
            ALU_COPY: res_q <= a_reg;
            ALU_MUL:  res_q <= a_reg;
            ALU_DIV: begin
              if (b_reg == '0) begin
                err_q  <= ERR_DIV0;
                halted <= 1'b1;
              end
            end
            ALU_MOD: begin
              if (b_reg == '0) begin
                err_q  <= ERR_MOD0;
                halted <= 1'b1;
              end
            end
            default: begin
              err_q  <= ERR_HALT;
              halted <= 1'b1;
            end
          endcase
        end
        if (uc.ldmd && !md_busy) begin
          res_q <= md_result;
        end

        if (uc.done) begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, error_code, call_start, take_target, out_value, out_valid};
            running  <= 1'b0;
            if (!dead && (op_q == OP_CALL)) begin
              caller_addr <= s1_addr;
            end
          end
        end else begin
          case (uc.br)
            BR_JUMP: pc <= uc.target;
            BR_WAIT: pc <= md_busy ? pc : pc + 4'd1;
            BR_NOMD: pc <= uses_md ? pc + 4'd1 : uc.target;
            default: pc <= pc + 4'd1;
          endcase
        end
      end
    end
  end

  taeu_muldiv #(
    .WIDTH (WORD_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .kind   (alu_q),
    .a      (a_reg),
    .b      (b_reg),
    .busy   (md_busy),
    .result (md_result)
  );

`ifndef SYNTHESIS
  // An instruction that arrived after a halt must never touch the memory.
  assert property (@(posedge clk) disable iff (rst) (running && dead) |-> !mem_we)
    else $error("memory written by an instruction issued while halted");

  // Nothing is taken during the clearing pass, so no result can appear then.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !m_tvalid)
    else $error("result presented during memory clearing");

  // The multiply/divide unit is only started from the assign program.
  assert property (@(posedge clk) disable iff (rst) md_start |-> (op_q == OP_ASSIGN && !dead))
    else $error("multiply/divide started outside an assign");

  // The halt is sticky until reset.
  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag cleared without reset");

  // An error result never carries an output value.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && (m_tdata[36:35] != ERR_NONE)) |-> !m_tdata[0])
    else $error("error result flagged as valid output");
`endif

endmodule

`default_nettype wire

[rtl/taeu_muldiv.sv]
// Iterative multiply and signed divide/modulo unit, one bit per cycle.
`default_nettype none

module taeu_muldiv #(
  parameter int WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire taeu_pkg::alu_op_t    kind,
  input  wire logic [WIDTH-1:0]     a,
  input  wire logic [WIDTH-1:0]     b,
  output logic                      busy,
  output logic [WIDTH-1:0]          result
);
  import taeu_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt;
  logic             is_mul;
  logic             is_div;
  logic             neg;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] acc;

  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] pick;

  assign mag_a  = a[WIDTH-1] ? (~a + WIDTH'(1)) : a;
  assign mag_b  = b[WIDTH-1] ? (~b + WIDTH'(1)) : b;
  assign rem_sh = {acc, x[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy   <= 1'b1;
      cnt    <= '0;
      is_mul <= (kind == ALU_MUL);
      is_div <= (kind == ALU_DIV);
      acc    <= '0;
      if (kind == ALU_MUL) begin
        x   <= a;
        y   <= b;
        neg <= 1'b0;
      end else begin
        x   <= mag_a;
        y   <= mag_b;
        neg <= (kind == ALU_DIV) ? (a[WIDTH-1] ^ b[WIDTH-1]) : a[WIDTH-1];
      end
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(WIDTH - 1)) begin
        busy <= 1'b0;
      end
      if (is_mul) begin
        acc <= acc + (x[0] ? y : '0);
        x   <= x >> 1;
        y   <= y << 1;
      end else if (!diff[WIDTH]) begin
        // Restoring division: the shifted remainder covers the divisor.
        acc <= diff[WIDTH-1:0];
        x   <= {x[WIDTH-2:0], 1'b1};
      end else begin
        acc <= rem_sh[WIDTH-1:0];
        x   <= {x[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    pick = is_div ? x : acc;
    if (!is_mul && neg) begin
      result = ~pick + WIDTH'(1);
    end else begin
      result = pick;
    end
  end

endmodule

`default_nettype wire
